// File: rtl/core/ple_pkg.sv
package ple_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int IW         = 32;
    localparam int PW         = 7;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int AW         = $clog2(DEPTH);

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_DUMP   = 3'd2;
    localparam logic [2:0] OP_MOVE   = 3'd3;
    localparam logic [2:0] OP_REV    = 3'd4;
    localparam logic [2:0] OP_ROTL   = 3'd5;
    localparam logic [2:0] OP_ROTR   = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NEG   = 2'd3;

    // per-cycle command to every cell of the chain
    localparam logic [2:0] CC_HOLD  = 3'd0;
    localparam logic [2:0] CC_INS   = 3'd1;  // cell at pos takes val, cells above pos take left neighbour
    localparam logic [2:0] CC_DEL   = 3'd2;  // cells at or above pos take right neighbour
    localparam logic [2:0] CC_ROTL  = 3'd3;  // cells below count take right, the top one wraps to the head
    localparam logic [2:0] CC_ROTR  = 3'd4;  // cells below count take left, cell 0 wraps to the tail

    typedef struct packed {
        logic [2:0]          cmd;
        logic [AW-1:0]       pos;
        logic [CW-1:0]       cnt;
        logic [WORD_WIDTH-1:0] val;
    } ctl_t;

endpackage

// File: rtl/core/ple_cell.sv
module ple_cell (
    input  logic                        aclk,
    input  ple_pkg::ctl_t               ctl,
    input  logic [ple_pkg::AW-1:0]      idx,
    input  logic [ple_pkg::WORD_WIDTH-1:0] left_in,
    input  logic [ple_pkg::WORD_WIDTH-1:0] right_in,
    input  logic [ple_pkg::WORD_WIDTH-1:0] wrap_lo,
    input  logic [ple_pkg::WORD_WIDTH-1:0] wrap_hi,
    output logic [ple_pkg::WORD_WIDTH-1:0] word
);
    import ple_pkg::*;

    logic [WORD_WIDTH-1:0] word_reg, word_next;
    logic [CW-1:0]         idx_w;

    assign idx_w = CW'(idx);
    assign word  = word_reg;

    // one slot of the list; neighbours feed it each cycle
    always_comb begin
        word_next = word_reg;
        case (ctl.cmd)
            CC_INS: begin
                if (idx == ctl.pos) word_next = ctl.val;
                else if (idx > ctl.pos) word_next = left_in;
            end
            CC_DEL: if (idx >= ctl.pos) word_next = right_in;
            CC_ROTL: begin
                if (idx_w + 1'b1 == ctl.cnt) word_next = wrap_lo;
                else if (idx_w < ctl.cnt) word_next = right_in;
            end
            CC_ROTR: begin
                if (idx == '0) word_next = wrap_hi;
                else if (idx_w < ctl.cnt) word_next = left_in;
            end
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end
endmodule

// File: rtl/core/ple_chain.sv
module ple_chain (
    input  logic                        aclk,
    input  ple_pkg::ctl_t               ctl,
    input  logic [ple_pkg::AW-1:0]      rd_idx,
    output logic [ple_pkg::WORD_WIDTH-1:0] rd_word,
    output logic [ple_pkg::WORD_WIDTH-1:0] head_word
);
    import ple_pkg::*;

    logic [WORD_WIDTH-1:0] w [DEPTH];
    logic [WORD_WIDTH-1:0] wrap_hi;

    // taps used by wrap-around rotation and by the sequencer
    assign wrap_hi = w[AW'(ctl.cnt - 1'b1)];
    assign rd_word = w[rd_idx];
    assign head_word = w[0];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            ple_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .idx      (AW'(g)),
                .left_in  (w[(g == 0) ? 0 : g - 1]),
                .right_in (w[(g == DEPTH - 1) ? g : g + 1]),
                .wrap_lo  (w[0]),
                .wrap_hi  (wrap_hi),
                .word     (w[g])
            );
        end
    endgenerate
endmodule

// File: rtl/core/positional_list_editor_top.sv
// Insert, remove and status-only results are registered. Move deletes its source word,
// then inserts it at the second position. Reverse inserts the current tail at each slot,
// head first. Rotate: serial remainder by the length, then min(k mod n, n - k mod n)
// single-place steps. Dump: one item per cycle while m_tready is high.
// One command at a time: the next is taken the cycle after its last result has gone.
// aresetn (synchronous, active low) empties the list; stored words are not cleared.
module positional_list_editor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] opcode, [34:3] operand_value, [41:35] first_position,
    // [48:42] second_position, zero pad to 56
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] item_word, [33:32] status, pad to 40
    output logic [39:0] m_tdata,
    // [0] list_empty
    output logic        m_tuser,
    output logic        m_tlast
);
    import ple_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MOD  = 4'd1;
    localparam logic [3:0] S_ROT  = 4'd2;
    localparam logic [3:0] S_REV  = 4'd3;
    localparam logic [3:0] S_MV1  = 4'd4;
    localparam logic [3:0] S_MV2  = 4'd5;
    localparam logic [3:0] S_DUMP = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0]      st_reg, st_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [2:0]      op_reg, op_next;
    logic [IW-1:0]   rem_reg, rem_next;     // modulo remainder, then step count
    logic [IW-1:0]   quo_reg, quo_next;     // dividend shift register
    logic [5:0]      bit_reg, bit_next;
    logic            rdir_reg, rdir_next;   // 1: rotate left steps
    logic [AW-1:0]   lo_reg, lo_next;
    logic [AW-1:0]   p2_reg, p2_next;
    logic [WORD_WIDTH-1:0] mv_reg, mv_next;
    logic            ov_reg, ov_next;
    // [31:0] item, [32] empty marker, [34:33] status
    logic [34:0]     od_reg, od_next;
    logic            ol_reg, ol_next;
    ctl_t            ctl;
    logic [AW-1:0]   rd_idx;
    logic [WORD_WIDTH-1:0] rd_word, head_word;

    logic [2:0]  in_op;
    logic [IW-1:0] in_val;
    logic [PW-1:0] in_p1, in_p2;
    logic [IW:0] trial;
    logic [CW-1:0] rot_amt;

    assign in_op  = s_tdata[2:0];
    assign in_val = s_tdata[34:3];
    assign in_p1  = s_tdata[41:35];
    assign in_p2  = s_tdata[48:42];

    assign s_tready = (st_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'd0, od_reg[34:33], od_reg[31:0]};
    assign m_tuser  = od_reg[32];
    assign m_tlast  = ol_reg;

    assign trial = {rem_reg, quo_reg[IW-1]} - {{(IW-CW+1){1'b0}}, cnt_reg};
    assign rot_amt = CW'(rem_reg);

    // reverse reads the tail, move reads its source
    assign rd_idx = (st_reg == S_REV) ? AW'(cnt_reg - 1'b1) : lo_reg;

    ple_chain u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .rd_idx    (rd_idx),
        .rd_word   (rd_word),
        .head_word (head_word)
    );

    // sequencer
    always_comb begin
        st_next = st_reg; cnt_next = cnt_reg; op_next = op_reg;
        rem_next = rem_reg; quo_next = quo_reg; bit_next = bit_reg;
        rdir_next = rdir_reg; lo_next = lo_reg;
        p2_next = p2_reg; mv_next = mv_reg;
        ov_next = ov_reg; od_next = od_reg; ol_next = ol_reg;
        ctl = '{cmd: CC_HOLD, pos: lo_reg, cnt: cnt_reg, val: mv_reg};

        if (ov_reg && m_tready) ov_next = 1'b0;

        case (st_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    od_next = '0; ol_next = 1'b0; ov_next = 1'b1;
                    op_next = in_op;
                    case (in_op)
                        OP_INSERT: begin
                            if (cnt_reg == CW'(DEPTH)) od_next[34:33] = ST_FULL;
                            else if (PW'(cnt_reg) < in_p1) od_next[34:33] = ST_RANGE;
                            else begin
                                ctl.cmd = CC_INS; ctl.pos = AW'(in_p1);
                                ctl.val = WORD_WIDTH'($signed(in_val));
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (in_p1 >= PW'(cnt_reg)) od_next[34:33] = ST_RANGE;
                            else begin
                                ctl.cmd = CC_DEL; ctl.pos = AW'(in_p1);
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        OP_DUMP: begin
                            if (cnt_reg == '0) begin
                                od_next[32] = 1'b1; ol_next = 1'b1;
                            end else begin
                                ov_next = 1'b0; lo_next = '0; st_next = S_DUMP;
                            end
                        end
                        OP_MOVE: begin
                            if (in_p1 >= PW'(cnt_reg) || in_p2 >= PW'(cnt_reg))
                                od_next[34:33] = ST_RANGE;
                            else begin
                                ov_next = 1'b0; lo_next = AW'(in_p1);
                                p2_next = AW'(in_p2); st_next = S_MV1;
                            end
                        end
                        OP_REV: begin
                            if (cnt_reg > CW'(1)) begin
                                ov_next = 1'b0; lo_next = '0; st_next = S_REV;
                            end
                        end
                        OP_ROTL, OP_ROTR: begin
                            if (in_val[IW-1]) od_next[34:33] = ST_NEG;
                            else if (cnt_reg != '0) begin
                                ov_next = 1'b0; rem_next = '0; quo_next = in_val;
                                bit_next = 6'(IW); st_next = S_MOD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // restoring division, one quotient bit per cycle
            S_MOD: begin
                if (bit_reg == '0) begin
                    // choose the shorter direction
                    if ({rot_amt, 1'b0} <= {1'b0, cnt_reg}) begin
                        rdir_next = (op_reg == OP_ROTL);
                    end else begin
                        rdir_next = (op_reg != OP_ROTL);
                        rem_next = IW'(cnt_reg - rot_amt);
                    end
                    st_next = S_ROT;
                end else begin
                    if (!trial[IW]) rem_next = trial[IW-1:0];
                    else rem_next = {rem_reg[IW-2:0], quo_reg[IW-1]};
                    quo_next = {quo_reg[IW-2:0], 1'b0};
                    bit_next = bit_reg - 1'b1;
                end
            end
            S_ROT: begin
                if (rem_reg == '0) begin
                    ov_next = 1'b1; st_next = S_IDLE;
                end else begin
                    ctl.cmd = rdir_reg ? CC_ROTL : CC_ROTR;
                    rem_next = rem_reg - 1'b1;
                end
            end
            // the current tail is inserted at slot lo, lo walking up
            S_REV: begin
                if (CW'(lo_reg) + 1'b1 == cnt_reg) begin
                    ov_next = 1'b1; st_next = S_IDLE;
                end else begin
                    ctl.cmd = CC_INS; ctl.pos = lo_reg; ctl.val = rd_word;
                    lo_next = lo_reg + 1'b1;
                end
            end
            S_MV1: begin
                mv_next = rd_word;
                ctl.cmd = CC_DEL;
                st_next = S_MV2;
            end
            S_MV2: begin
                ctl.cmd = CC_INS; ctl.pos = p2_reg; ctl.val = mv_reg;
                ov_next = 1'b1; st_next = S_IDLE;
            end
            S_DUMP: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                    od_next = {3'd0, head_word[31:0]};
                    ol_next = (cnt_reg == CW'(1)) ? 1'b1 : 1'b0;
                    // read from the head and rotate one place
                    ctl.cmd = CC_ROTL;
                    lo_next = lo_reg + 1'b1;
                    if (CW'(lo_reg) + 1'b1 == cnt_reg) st_next = S_OUT;
                    else ol_next = 1'b0;
                    if (CW'(lo_reg) + 1'b1 == cnt_reg) ol_next = 1'b1;
                end
            end
            S_OUT: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; cnt_reg <= '0; ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next; cnt_reg <= cnt_next; ov_reg <= ov_next;
        end
        op_reg <= op_next; rem_reg <= rem_next; quo_reg <= quo_next;
        bit_reg <= bit_next; rdir_reg <= rdir_next; lo_reg <= lo_next;
        p2_reg <= p2_next; mv_reg <= mv_next;
        od_reg <= od_next; ol_reg <= ol_next;
    end

    property p_cnt_max;
        @(posedge aclk) disable iff (!aresetn) cnt_reg <= CW'(DEPTH);
    endproperty
    a_cnt_max: assert property (p_cnt_max) else $error("count beyond depth");

    property p_busy_no_take;
        @(posedge aclk) disable iff (!aresetn) (st_reg != S_IDLE) |-> !s_tready;
    endproperty
    a_busy: assert property (p_busy_no_take) else $error("ready while busy");

    property p_last_ok;
        @(posedge aclk) disable iff (!aresetn) (ov_reg && ol_reg) |-> (od_reg[34:33] == ST_OK);
    endproperty
    a_last: assert property (p_last_ok) else $error("last with status");
endmodule

// File: tb/positional_list_editor_top_test.sv
module positional_list_editor_top_test;
    import ple_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] OP_SPARE = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] operand;
        logic [6:0]  pos_a;
        logic [6:0]  pos_b;
    } command_t;

    typedef struct packed {
        logic [31:0] word;
        logic        empty;
        logic [1:0]  stat;
        logic        last;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    command_t pending_cmds[$];
    answer_t  expected_answers[$];
    logic [31:0] shadow_list[$];
    int error_count = 0;
    int idle_cycles = 0;
    int cycle_no = 0;
    bit stimulus_done = 1'b0;

    positional_list_editor_top dut (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_no, what);
        error_count++;
    endtask

    function automatic answer_t status_answer(input logic [1:0] st);
        answer_t a;
        a = '0;
        a.stat = st;
        return a;
    endfunction

    // list editor model: applies one command, queues its answers
    task automatic apply_command(input command_t c);
        logic [31:0] v;
        int n;
        int amt;
        answer_t a;
        n = shadow_list.size();
        case (c.op)
            OP_INSERT: begin
                if (n >= DEPTH) expected_answers.push_back(status_answer(ST_FULL));
                else if (c.pos_a > n) expected_answers.push_back(status_answer(ST_RANGE));
                else begin
                    shadow_list.insert(c.pos_a, c.operand);
                    expected_answers.push_back(status_answer(ST_OK));
                end
            end
            OP_REMOVE: begin
                if (c.pos_a < n) begin
                    shadow_list.delete(c.pos_a);
                    expected_answers.push_back(status_answer(ST_OK));
                end else expected_answers.push_back(status_answer(ST_RANGE));
            end
            OP_DUMP: begin
                if (n == 0) begin
                    a = '0;
                    a.empty = 1'b1;
                    a.last = 1'b1;
                    expected_answers.push_back(a);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        a = '0;
                        a.word = shadow_list[i];
                        a.last = (i == n - 1);
                        expected_answers.push_back(a);
                    end
                end
            end
            OP_MOVE: begin
                if (c.pos_a < n && c.pos_b < n) begin
                    v = shadow_list[c.pos_a];
                    shadow_list.delete(c.pos_a);
                    shadow_list.insert(c.pos_b, v);
                    expected_answers.push_back(status_answer(ST_OK));
                end else expected_answers.push_back(status_answer(ST_RANGE));
            end
            OP_REV: begin
                shadow_list.reverse();
                expected_answers.push_back(status_answer(ST_OK));
            end
            OP_ROTL, OP_ROTR: begin
                if (c.operand[31]) expected_answers.push_back(status_answer(ST_NEG));
                else begin
                    if (n != 0) begin
                        amt = c.operand % n;
                        if (c.op == OP_ROTR) amt = (n - amt) % n;
                        repeat (amt) begin
                            v = shadow_list.pop_front();
                            shadow_list.push_back(v);
                        end
                    end
                    expected_answers.push_back(status_answer(ST_OK));
                end
            end
            default: expected_answers.push_back(status_answer(ST_OK));
        endcase
    endtask

    function automatic command_t make_cmd(input logic [2:0] op, input logic [31:0] val,
                                          input logic [6:0] a, input logic [6:0] b);
        command_t c;
        c.op = op;
        c.operand = val;
        c.pos_a = a;
        c.pos_b = b;
        return c;
    endfunction

    // random position: mostly near the live range, sometimes anywhere
    function automatic logic [6:0] rand_pos();
        if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, 40));
    endfunction

    // stimulus
    initial begin
        logic [2:0] op;
        // directed: empty-list cases, extremes, full store
        pending_cmds.push_back(make_cmd(OP_DUMP, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ROTL, 5, 0, 0));
        pending_cmds.push_back(make_cmd(OP_MOVE, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 32'h8000_0000, 1, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 32'h8000_0000, 0, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 32'h7FFF_FFFF, 1, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 32'hFFFF_FFFF, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ROTR, 32'hFFFF_FFFF, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ROTL, 32'h7FFF_FFFF, 0, 0));
        pending_cmds.push_back(make_cmd(OP_MOVE, 0, 2, 2));
        pending_cmds.push_back(make_cmd(OP_MOVE, 0, 0, 3));
        pending_cmds.push_back(make_cmd(OP_REV, 0, 127, 127));
        pending_cmds.push_back(make_cmd(OP_SPARE, 32'hFFFF_FFFF, 127, 127));
        pending_cmds.push_back(make_cmd(OP_DUMP, 0, 0, 0));
        for (int i = 0; i < 64; i++)
            pending_cmds.push_back(make_cmd(OP_INSERT, $urandom, 0, 0));
        pending_cmds.push_back(make_cmd(OP_INSERT, 1, 0, 0));
        pending_cmds.push_back(make_cmd(OP_MOVE, 0, 63, 0));
        pending_cmds.push_back(make_cmd(OP_ROTR, 100, 0, 0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 64, 0));
        pending_cmds.push_back(make_cmd(OP_DUMP, 0, 0, 0));
        for (int i = 0; i < 64; i++)
            pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 7'($urandom_range(0, 63 - i)), 0));
        // random: inserts weighted so the list grows, dumps now and then
        for (int i = 0; i < 300; i++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: op = OP_INSERT;
                5, 6:          op = OP_REMOVE;
                7:             op = OP_DUMP;
                8, 9:          op = OP_MOVE;
                10:            op = OP_REV;
                11, 12:        op = OP_ROTL;
                13, 14:        op = OP_ROTR;
                default:       op = OP_SPARE;
            endcase
            if (op == OP_ROTL || op == OP_ROTR)
                pending_cmds.push_back(make_cmd(op, ($urandom_range(0, 7) == 0) ? $urandom
                                                : $urandom_range(0, 200),
                                                rand_pos(), rand_pos()));
            else
                pending_cmds.push_back(make_cmd(op, $urandom, rand_pos(), rand_pos()));
        end
        pending_cmds.push_back(make_cmd(OP_DUMP, 0, 0, 0));
        stimulus_done = 1'b1;
    end

    // reset
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == 1) aresetn <= 1'b1;
    end

    // idling allowed except in a quiet stretch
    function automatic bit take_gap();
        if (cycle_no > 3000 && cycle_no < 6000) return 1'b0;
        return $urandom_range(0, 99) < 32;
    endfunction

    // driver
    always @(posedge aclk) begin
        command_t c;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c.op      = s_tdata[2:0];
                c.operand = s_tdata[34:3];
                c.pos_a   = s_tdata[41:35];
                c.pos_b   = s_tdata[48:42];
                apply_command(c);
            end
            if ((!s_tvalid || s_tready) && pending_cmds.size() != 0 && !take_gap()) begin
                c = pending_cmds.pop_front();
                s_tdata <= {7'b0, c.pos_b, c.pos_a, c.operand, c.op};
                s_tvalid <= 1'b1;
            end else if (s_tvalid && s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) report("transaction with nothing expected");
                else begin
                    e = expected_answers.pop_front();
                    if (m_tdata[31:0] !== e.word)
                        report($sformatf("item_word %h, want %h", m_tdata[31:0], e.word));
                    if (m_tuser !== e.empty)
                        report($sformatf("list_empty %b, want %b", m_tuser, e.empty));
                    if (m_tdata[33:32] !== e.stat)
                        report($sformatf("status %0d, want %0d", m_tdata[33:32], e.stat));
                    if (m_tlast !== e.last)
                        report($sformatf("tlast %b, want %b", m_tlast, e.last));
                end
            end
            m_tready <= !take_gap();
        end
    end

    // watchdog and end of run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else if (stimulus_done && pending_cmds.size() == 0 && !s_tvalid
                     && expected_answers.size() == 0 && idle_cycles >= 200) begin
            if (error_count == 0) $display("DONE: 0 errors");
            else $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
